// ===== design/pdct_pkg.sv =====
// Shared types, constants and the high-half translation table for the percent decoder.
package pdct_pkg;

  localparam int XLAT_ENTRIES = 128;
  localparam int XLAT_IDX_W = $clog2(XLAT_ENTRIES);

  localparam logic [7:0] CHAR_PERCENT = 8'h25;
  localparam logic [7:0] CHAR_NUL = 8'h00;

  // Escape tracking state of the front end.
  typedef enum logic [1:0] {
    PEND_NONE  = 2'd0,
    PEND_PCT   = 2'd1,
    PEND_DIGIT = 2'd2
  } pend_state_t;

  // What the request's own byte turns into after any flushed escape bytes.
  typedef enum logic [1:0] {
    TAIL_NONE = 2'd0,
    TAIL_LIT  = 2'd1,
    TAIL_XLAT = 2'd2,
    TAIL_TERM = 2'd3
  } tail_kind_t;

  // One queued request: flushed prefix ('%' and maybe a held digit), then a tail.
  typedef struct packed {
    logic [1:0] prefix;
    logic [7:0] held_digit;
    tail_kind_t tail_kind;
    logic [7:0] tail_byte;
  } q_entry_t;

  // Mac Roman high half to Windows-1252; a zero entry means the byte is dropped.
  localparam logic [7:0] XLAT_ROM [XLAT_ENTRIES] = '{
    8'd196, 8'd197, 8'd199, 8'd201, 8'd209, 8'd214, 8'd220, 8'd225,
    8'd224, 8'd226, 8'd228, 8'd227, 8'd229, 8'd231, 8'd233, 8'd232,
    8'd234, 8'd235, 8'd237, 8'd236, 8'd238, 8'd239, 8'd241, 8'd243,
    8'd242, 8'd244, 8'd246, 8'd245, 8'd250, 8'd249, 8'd251, 8'd252,
    8'd134, 8'd176, 8'd162, 8'd163, 8'd167, 8'd149, 8'd182, 8'd223,
    8'd174, 8'd169, 8'd0,   8'd180, 8'd168, 8'd0,   8'd198, 8'd216,
    8'd0,   8'd177, 8'd0,   8'd0,   8'd165, 8'd181, 8'd0,   8'd0,
    8'd215, 8'd0,   8'd0,   8'd170, 8'd186, 8'd0,   8'd230, 8'd248,
    8'd191, 8'd161, 8'd172, 8'd0,   8'd131, 8'd0,   8'd0,   8'd171,
    8'd187, 8'd133, 8'd160, 8'd192, 8'd195, 8'd213, 8'd140, 8'd156,
    8'd150, 8'd151, 8'd147, 8'd148, 8'd145, 8'd146, 8'd247, 8'd0,
    8'd255, 8'd159, 8'd0,   8'd164, 8'd139, 8'd155, 8'd0,   8'd0,
    8'd135, 8'd0,   8'd130, 8'd132, 8'd137, 8'd194, 8'd202, 8'd193,
    8'd203, 8'd200, 8'd205, 8'd206, 8'd207, 8'd204, 8'd211, 8'd212,
    8'd0,   8'd210, 8'd218, 8'd219, 8'd217, 8'd0,   8'd136, 8'd152,
    8'd175, 8'd0,   8'd0,   8'd176, 8'd184, 8'd0,   8'd0,   8'd0
  };

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
             (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30;
    else if (c >= 8'h41 && c <= 8'h46) v = c - 8'h37;
    else if (c >= 8'h61 && c <= 8'h66) v = c - 8'h57;
    hex_value = v[3:0];
  endfunction

endpackage

// ===== design/pdct_front.sv =====
// Front end: accepts input bytes, tracks escapes and queues classified requests.
module pdct_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_byte,
  input  logic             q_ready,
  output logic             q_push,
  output pdct_pkg::q_entry_t q_entry
);

  pdct_pkg::pend_state_t state, state_next;
  logic [7:0] held_digit, held_digit_next;
  logic       accept, need_push;

  assign in_ready = q_ready;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept && need_push;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= pdct_pkg::PEND_NONE;
      held_digit <= 8'h00;
    end else begin
      state      <= state_next;
      held_digit <= held_digit_next;
    end
  end

  always_comb begin
    pdct_pkg::tail_kind_t kind;
    logic hex;
    hex = pdct_pkg::is_hex(in_byte);
    if (in_byte == pdct_pkg::CHAR_NUL) kind = pdct_pkg::TAIL_TERM;
    else if (in_byte == pdct_pkg::CHAR_PERCENT) kind = pdct_pkg::TAIL_NONE;
    else if (in_byte[7]) kind = pdct_pkg::TAIL_XLAT;
    else kind = pdct_pkg::TAIL_LIT;

    state_next           = state;
    held_digit_next      = held_digit;
    need_push            = 1'b0;
    q_entry.prefix       = 2'd0;
    q_entry.held_digit   = held_digit;
    q_entry.tail_kind    = kind;
    q_entry.tail_byte    = in_byte;

    if (accept) begin
      case (state)
        pdct_pkg::PEND_PCT: begin
          if (hex) begin
            state_next      = pdct_pkg::PEND_DIGIT;
            held_digit_next = in_byte;
          end else begin
            // Broken escape: flush the '%', then the byte as if nothing were held.
            need_push      = 1'b1;
            q_entry.prefix = 2'd1;
            state_next     = (in_byte == pdct_pkg::CHAR_PERCENT) ?
                             pdct_pkg::PEND_PCT : pdct_pkg::PEND_NONE;
          end
        end
        pdct_pkg::PEND_DIGIT: begin
          need_push = 1'b1;
          if (hex) begin
            state_next        = pdct_pkg::PEND_NONE;
            q_entry.tail_kind = pdct_pkg::TAIL_LIT;
            q_entry.tail_byte = {pdct_pkg::hex_value(held_digit),
                                 pdct_pkg::hex_value(in_byte)};
          end else begin
            q_entry.prefix = 2'd2;
            state_next     = (in_byte == pdct_pkg::CHAR_PERCENT) ?
                             pdct_pkg::PEND_PCT : pdct_pkg::PEND_NONE;
          end
        end
        default: begin
          if (in_byte == pdct_pkg::CHAR_PERCENT) begin
            state_next = pdct_pkg::PEND_PCT;
          end else begin
            need_push  = 1'b1;
            state_next = pdct_pkg::PEND_NONE;
          end
        end
      endcase
    end
  end

  // A digit is held only while the second digit of an escape is awaited.
  a_digit_held_is_hex: assert property (@(posedge clk) disable iff (rst)
    state == pdct_pkg::PEND_DIGIT |-> pdct_pkg::is_hex(held_digit))
    else $error("held digit is not a hex digit");

endmodule

// ===== design/pdct_queue.sv =====
// Small request queue between the front end and the back end.
module pdct_queue #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  pdct_pkg::q_entry_t push_data,
  output logic               push_ready,
  input  logic               pop,
  output logic               pop_valid,
  output pdct_pkg::q_entry_t pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  pdct_pkg::q_entry_t slots [DEPTH];
  logic [AW:0] wptr, rptr;
  logic        full, empty;

  assign empty      = (wptr == rptr);
  assign full       = (wptr[AW] != rptr[AW]) && (wptr[AW-1:0] == rptr[AW-1:0]);
  assign push_ready = !full;
  assign pop_valid  = !empty;
  assign pop_data   = slots[rptr[AW-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
    end else begin
      if (push && !full) wptr <= wptr + 1'b1;
      if (pop && !empty) rptr <= rptr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) slots[wptr[AW-1:0]] <= push_data;
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("request pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) empty |-> !pop)
    else $error("request popped from an empty queue");

endmodule

// ===== design/pdct_back.sv =====
// Back end: expands each request into its bytes, one per cycle unless stalled.
module pdct_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  pdct_pkg::q_entry_t q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte,
  output logic               is_terminator,
  output logic               last_of_run
);

  logic [1:0] step, step_next;
  logic       out_valid_next;
  logic [7:0] out_byte_next;
  logic       term_next, last_next;
  logic [7:0] rom_byte;
  logic       tail_emits, advance, at_last;
  logic [1:0] n_total;

  assign rom_byte   = pdct_pkg::XLAT_ROM[q_head.tail_byte[pdct_pkg::XLAT_IDX_W-1:0]];
  assign tail_emits = (q_head.tail_kind == pdct_pkg::TAIL_LIT) ||
                      (q_head.tail_kind == pdct_pkg::TAIL_TERM) ||
                      ((q_head.tail_kind == pdct_pkg::TAIL_XLAT) && (rom_byte != 8'h00));
  assign n_total    = q_head.prefix + {1'b0, tail_emits};
  assign advance    = q_valid && (!out_valid || out_ready);
  assign at_last    = (step == n_total - 2'd1);
  assign q_pop      = advance && ((n_total == 2'd0) || at_last);

  always_comb begin
    step_next      = step;
    out_valid_next = out_valid && !out_ready;
    out_byte_next  = out_byte;
    term_next      = is_terminator;
    last_next      = last_of_run;
    if (advance && n_total != 2'd0) begin
      out_valid_next = 1'b1;
      last_next      = at_last;
      term_next      = 1'b0;
      step_next      = at_last ? 2'd0 : step + 2'd1;
      if (step < q_head.prefix) begin
        out_byte_next = (step == 2'd0) ? pdct_pkg::CHAR_PERCENT : q_head.held_digit;
      end else begin
        case (q_head.tail_kind)
          pdct_pkg::TAIL_TERM: begin
            out_byte_next = pdct_pkg::CHAR_NUL;
            term_next     = 1'b1;
          end
          pdct_pkg::TAIL_XLAT: out_byte_next = rom_byte;
          default:             out_byte_next = q_head.tail_byte;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_byte      <= out_byte_next;
    is_terminator <= term_next;
    last_of_run   <= last_next;
  end

  // Partway through a request, that request must still sit at the queue head.
  a_step_has_head: assert property (@(posedge clk) disable iff (rst)
    step != 2'd0 |-> q_valid && step < n_total)
    else $error("result step outruns its request");

endmodule

// ===== design/percent_decode_charset_translate.sv =====
// Top level of the percent decoder with high-half character translation.
//
//  Channel  Direction  Handshake               Payload
//  input    in         in_valid / in_ready     in_byte
//  output   out        out_valid / out_ready   out_byte, is_terminator, last_of_run
//
// One input byte is taken per cycle while the request queue has room.
// Each request leaves the back end at one result per cycle while out_ready allows
// and holds it until its last result is taken; a dropped high byte passes with no
// result, and a byte that only opens or extends an escape never reaches it.
// A result is registered at the queue write, then at the output register.
// Stalls on the output side fill the QUEUE_DEPTH-entry queue before in_ready drops.
// Reset clears the escape state, queue pointers, back-end step and output valid.
module percent_decode_charset_translate #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       is_terminator,
  output logic       last_of_run
);

  // Requests from the front end carry the escape bytes still to be flushed and
  // a classified tail; the back end performs the table lookup and serializes.
  pdct_pkg::q_entry_t push_entry, head_entry;
  logic push, push_ready, pop, head_valid;

  pdct_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .q_ready  (push_ready),
    .q_push   (push),
    .q_entry  (push_entry)
  );

  pdct_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_entry),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_valid  (head_valid),
    .pop_data   (head_entry)
  );

  pdct_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (head_valid),
    .q_head        (head_entry),
    .q_pop         (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .is_terminator (is_terminator),
    .last_of_run   (last_of_run)
  );

  // The terminator is always the final, zero-valued result of its request.
  a_term_is_last_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_terminator |-> last_of_run && out_byte == pdct_pkg::CHAR_NUL)
    else $error("terminator result is malformed");

endmodule
